@@ hw/rtl/sbir_pkg.sv @@
`default_nettype none

package sbir_pkg;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  typedef struct packed {
    logic take;
    logic load;
    logic step;
    logic update;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic qual;
    logic last;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/sbir_ctrl.sv @@
`default_nettype none

module sbir_ctrl
  import sbir_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = status_i.qual ? S_DIV : S_UPD;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (!(status_i.last && out_valid_q && out_stall_i)) begin
          cmd_o.update   = 1'b1;
          cmd_o.out_load = status_i.last;
          if (status_i.last) begin
            out_valid_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/sbir_dp.sv @@
`default_nettype none

module sbir_dp
  import sbir_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire dp_cmd_t                cmd_i,
  output dp_status_t                  status_o,
  input  wire signed [DATA_WIDTH-1:0] point_value_i,
  input  wire signed [DATA_WIDTH-1:0] step_dir_i,
  input  wire signed [DATA_WIDTH-1:0] lower_bound_i,
  input  wire signed [DATA_WIDTH-1:0] upper_bound_i,
  input  wire                         has_lower_i,
  input  wire                         has_upper_i,
  input  wire                         last_item_i,
  output logic signed [DATA_WIDTH-1:0] closest_bound_o,
  output logic signed [DATA_WIDTH-1:0] wolfe_bound_o,
  output logic signed [DATA_WIDTH-1:0] farthest_bound_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned NW = DATA_WIDTH + FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(DATA_WIDTH + 1);
  localparam logic [W-1:0] INF_CODE = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_CODE = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MINUS_ONE = (FRAC_BITS >= DATA_WIDTH - 1) ? MIN_CODE :
                                       (~(W'(1) << FRAC_BITS) + W'(1));

  logic           qual_q, last_q, neg_q, ovf_q;
  logic [W-1:0]   nmag_q, dmag_q;
  logic [W-1:0]   r_q;
  logic [W:0]     nlo_q, q_q;
  logic [CW-1:0]  cnt_q;
  logic signed [W-1:0] run_min_q, run_wolfe_q, run_max_q;

  logic           pos_dir, neg_dir, qual_c, nneg_c;
  logic signed [W:0] bound_c, diff_c;
  logic [W-1:0]   nmag_c;
  logic [W-1:0]   dmag_c;
  logic [NW-1:0]  nfull, ntop;
  logic [W:0]     r_sh;
  logic           qbit;
  logic signed [W-1:0] t_c, min_c, wolfe_c, max_c;

  always_comb begin
    pos_dir = (step_dir_i > 0) && has_upper_i;
    neg_dir = (step_dir_i < 0) && has_lower_i;
    qual_c  = pos_dir || neg_dir;
    bound_c = pos_dir ? (W+1)'(upper_bound_i) : (W+1)'(lower_bound_i);
    diff_c  = bound_c - (W+1)'(point_value_i);
    nneg_c  = diff_c[W];
    nmag_c  = nneg_c ? W'(-diff_c) : W'(diff_c);
    dmag_c  = step_dir_i[W-1] ? (W'(0) - W'(step_dir_i)) : W'(step_dir_i);
  end

  always_comb begin
    nfull = NW'(nmag_q) << FRAC_BITS;
    ntop  = nfull >> (W + 1);
    r_sh  = {r_q, nlo_q[W]};
    qbit  = (r_sh >= {1'b0, dmag_q});
  end

  always_comb begin
    if (!neg_q) begin
      t_c = (ovf_q || q_q[W] || q_q[W-1]) ? INF_CODE : q_q[W-1:0];
    end else if (ovf_q || q_q[W] || (q_q[W-1] && (q_q[W-2:0] != '0))) begin
      t_c = MIN_CODE;
    end else begin
      t_c = W'(0) - q_q[W-1:0];
    end
    min_c   = run_min_q;
    wolfe_c = run_wolfe_q;
    max_c   = run_max_q;
    if (qual_q) begin
      if (t_c < run_min_q) begin
        min_c = t_c;
      end
      if ((min_c > 0) && (t_c < run_wolfe_q)) begin
        wolfe_c = t_c;
      end
      if (t_c > run_max_q) begin
        max_c = t_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      qual_q <= qual_c;
      last_q <= last_item_i;
      neg_q  <= nneg_c ^ step_dir_i[W-1];
      nmag_q <= nmag_c;
      dmag_q <= dmag_c;
    end
    if (cmd_i.load) begin
      ovf_q <= (ntop >= NW'(dmag_q));
      r_q   <= ntop[W-1:0];
      nlo_q <= nfull[W:0];
      q_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      r_q   <= qbit ? W'(r_sh - {1'b0, dmag_q}) : r_sh[W-1:0];
      nlo_q <= {nlo_q[W-1:0], 1'b0};
      q_q   <= {q_q[W-1:0], qbit};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.out_load) begin
      closest_bound_o  <= min_c;
      wolfe_bound_o    <= wolfe_c;
      farthest_bound_o <= (max_c < 0) ? INF_CODE : max_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q   <= INF_CODE;
      run_wolfe_q <= INF_CODE;
      run_max_q   <= MINUS_ONE;
    end else if (cmd_i.update) begin
      if (last_q) begin
        run_min_q   <= INF_CODE;
        run_wolfe_q <= INF_CODE;
        run_max_q   <= MINUS_ONE;
      end else begin
        run_min_q   <= min_c;
        run_wolfe_q <= wolfe_c;
        run_max_q   <= max_c;
      end
    end
  end

  assign status_o.qual     = qual_q;
  assign status_o.last     = last_q;
  assign status_o.div_last = (cnt_q == CW'(W));

endmodule

`default_nettype wire

@@ hw/rtl/step_bound_info_reduce.sv @@
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   point, direction, bounds, flags, last
// out      source     out_valid_o / out_stall_i closest, Wolfe and farthest bound
//
// An element whose step direction points at a bound that is present passes through the
// restoring divider (one quotient bit per cycle, DATA_WIDTH + 1 steps); others skip it.
// A result is produced only on the last element and waits in the output register.
// The final element of a vector stalls in its update cycle while that register is full and out_stall_i is high.
// Reset returns the running minimum, Wolfe minimum and maximum to their initial values.

module step_bound_info_reduce
  import sbir_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire signed [DATA_WIDTH-1:0]  point_value_i,
  input  wire signed [DATA_WIDTH-1:0]  step_dir_i,
  input  wire signed [DATA_WIDTH-1:0]  lower_bound_i,
  input  wire signed [DATA_WIDTH-1:0]  upper_bound_i,
  input  wire                          has_lower_i,
  input  wire                          has_upper_i,
  input  wire                          last_item_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0] closest_bound_o,
  output logic signed [DATA_WIDTH-1:0] wolfe_bound_o,
  output logic signed [DATA_WIDTH-1:0] farthest_bound_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sbir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbir_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .point_value_i    (point_value_i),
    .step_dir_i       (step_dir_i),
    .lower_bound_i    (lower_bound_i),
    .upper_bound_i    (upper_bound_i),
    .has_lower_i      (has_lower_i),
    .has_upper_i      (has_upper_i),
    .last_item_i      (last_item_i),
    .closest_bound_o  (closest_bound_o),
    .wolfe_bound_o    (wolfe_bound_o),
    .farthest_bound_o (farthest_bound_o)
  );

endmodule

`default_nettype wire

@@ test/tb_step_bound_info_reduce.sv @@
`default_nettype none

module tb_step_bound_info_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam logic signed [DW-1:0] INF_CODE = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_CODE = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE = 1 <<< FB;
  localparam logic signed [DW-1:0] MINUS_ONE = -(1 <<< FB);
  localparam int LONG_HOLD = 2000;
  localparam int PHASE_ITEMS = 400;

  typedef struct {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic has_lo;
    logic has_hi;
    logic last;
  } element_t;

  typedef logic [2:0][DW-1:0] bound_trio_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DW-1:0] point_value_i = '0;
  logic signed [DW-1:0] step_dir_i = '0;
  logic signed [DW-1:0] lower_bound_i = '0;
  logic signed [DW-1:0] upper_bound_i = '0;
  logic has_lower_i = 1'b0;
  logic has_upper_i = 1'b0;
  logic last_item_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DW-1:0] closest_bound_o;
  logic signed [DW-1:0] wolfe_bound_o;
  logic signed [DW-1:0] farthest_bound_o;

  step_bound_info_reduce #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .point_value_i   (point_value_i),
    .step_dir_i      (step_dir_i),
    .lower_bound_i   (lower_bound_i),
    .upper_bound_i   (upper_bound_i),
    .has_lower_i     (has_lower_i),
    .has_upper_i     (has_upper_i),
    .last_item_i     (last_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .closest_bound_o (closest_bound_o),
    .wolfe_bound_o   (wolfe_bound_o),
    .farthest_bound_o(farthest_bound_o)
  );

  element_t element_queue[$];
  bound_trio_t pending_bounds[$];
  element_t drive_elem;
  bound_trio_t got_trio;
  bound_trio_t want_trio;
  string field_name[3] = '{"closest_bound", "wolfe_bound", "farthest_bound"};

  logic signed [DW-1:0] run_closest;
  logic signed [DW-1:0] run_wolfe;
  logic signed [DW-1:0] run_farthest;

  logic in_fire = 1'b0;
  logic hold_arm = 1'b0;
  int hold_left = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 77;
  int fail_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic signed [DW-1:0] bound_ratio(logic signed [DW-1:0] bound,
                                                       logic signed [DW-1:0] x,
                                                       logic signed [DW-1:0] dx);
    longint num;
    longint quo;
    num = (longint'(bound) - longint'(x)) * (longint'(1) <<< FB);
    quo = num / longint'(dx);
    if (quo > longint'(INF_CODE)) return INF_CODE;
    if (quo < longint'(MIN_CODE)) return MIN_CODE;
    return quo[DW-1:0];
  endfunction

  task automatic clear_bounds();
    run_closest = INF_CODE;
    run_wolfe = INF_CODE;
    run_farthest = MINUS_ONE;
  endtask

  task automatic fold_element(element_t e);
    logic signed [DW-1:0] t;
    logic hit;
    bound_trio_t trio;
    hit = 1'b0;
    t = '0;
    if (e.dx > 0 && e.has_hi) begin
      t = bound_ratio(e.hi, e.x, e.dx);
      hit = 1'b1;
    end else if (e.dx < 0 && e.has_lo) begin
      t = bound_ratio(e.lo, e.x, e.dx);
      hit = 1'b1;
    end
    if (hit) begin
      if (t < run_closest) run_closest = t;
      if (run_closest > 0 && t < run_wolfe) run_wolfe = t;
      if (t > run_farthest) run_farthest = t;
    end
    if (e.last) begin
      trio[0] = run_closest;
      trio[1] = run_wolfe;
      trio[2] = (run_farthest < 0) ? INF_CODE : run_farthest;
      pending_bounds.push_back(trio);
      clear_bounds();
    end
  endtask

  task automatic add_item(logic signed [DW-1:0] x, logic signed [DW-1:0] dx,
                          logic signed [DW-1:0] lo, logic signed [DW-1:0] hi,
                          logic has_lo, logic has_hi, logic last);
    element_t e;
    e.x = x;
    e.dx = dx;
    e.lo = lo;
    e.hi = hi;
    e.has_lo = has_lo;
    e.has_hi = has_hi;
    e.last = last;
    element_queue.push_back(e);
  endtask

  function automatic logic signed [DW-1:0] pick_word();
    int v;
    case ($urandom_range(11))
      0, 1, 2, 3, 4, 5: begin
        v = $urandom_range(0, 32'h0020_0000);
        return v - 32'h0010_0000;
      end
      6, 7: return $urandom;
      8: return INF_CODE;
      9: return MIN_CODE;
      10: return '0;
      default: return $urandom_range(1) ? 1 : -1;
    endcase
  endfunction

  task automatic add_random_vectors(int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        add_item(pick_word(), ($urandom_range(7) == 0) ? '0 : pick_word(), pick_word(),
                 pick_word(), $urandom_range(1), $urandom_range(1), i == len - 1);
      end
      n += len;
    end
  endtask

  task automatic drain();
    while (element_queue.size() != 0 || in_valid_i || pending_bounds.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (element_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_elem = element_queue.pop_front();
        point_value_i <= drive_elem.x;
        step_dir_i <= drive_elem.dx;
        lower_bound_i <= drive_elem.lo;
        upper_bound_i <= drive_elem.hi;
        has_lower_i <= drive_elem.has_lo;
        has_upper_i <= drive_elem.has_hi;
        last_item_i <= drive_elem.last;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_arm) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= hold_arm || hold_left > 1 || $urandom_range(99) < recv_idle_pct;
  end

  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bounds.size() == 0) begin
        if (fail_count < 10) begin
          $display("%0t: result with none expected: %0d %0d %0d", $realtime,
                   closest_bound_o, wolfe_bound_o, farthest_bound_o);
        end
        fail_count++;
      end else begin
        want_trio = pending_bounds.pop_front();
        got_trio[0] = closest_bound_o;
        got_trio[1] = wolfe_bound_o;
        got_trio[2] = farthest_bound_o;
        for (int i = 0; i < 3; i++) begin
          if (got_trio[i] !== want_trio[i]) begin
            if (fail_count < 10) begin
              $display("%0t: %s expected %0d got %0d", $realtime, field_name[i],
                       $signed(want_trio[i]), $signed(got_trio[i]));
            end
            fail_count++;
          end
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      fold_element('{point_value_i, step_dir_i, lower_bound_i, upper_bound_i,
                     has_lower_i, has_upper_i, last_item_i});
    end
  end

  initial begin
    clear_bounds();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_item('0, '0, '0, '0, 1'b1, 1'b1, 1'b1);
    add_item('0, ONE, '0, 2 * ONE, 1'b0, 1'b1, 1'b0);
    add_item('0, MINUS_ONE, -3 * ONE, '0, 1'b1, 1'b0, 1'b0);
    add_item(ONE, MINUS_ONE, '0, '0, 1'b0, 1'b1, 1'b0);
    add_item(ONE, ONE, '0, '0, 1'b1, 1'b0, 1'b1);
    add_item(MIN_CODE, 1, '0, INF_CODE, 1'b0, 1'b1, 1'b0);
    add_item(INF_CODE, 1, '0, MIN_CODE, 1'b0, 1'b1, 1'b1);
    add_item(4 * ONE, ONE, '0, ONE, 1'b0, 1'b1, 1'b1);
    add_item('0, ONE, '0, 5 * ONE, 1'b0, 1'b1, 1'b0);
    add_item('0, MINUS_ONE, ONE, '0, 1'b1, 1'b0, 1'b0);
    add_item('0, ONE, '0, ONE, 1'b0, 1'b1, 1'b1);
    add_item('0, MIN_CODE, INF_CODE, '0, 1'b1, 1'b1, 1'b0);
    add_item('0, INF_CODE, '0, MIN_CODE, 1'b1, 1'b1, 1'b0);
    add_item(MIN_CODE, INF_CODE, INF_CODE, INF_CODE, 1'b1, 1'b1, 1'b0);
    add_item(-1, -1, MIN_CODE, INF_CODE, 1'b1, 1'b1, 1'b1);
    add_item(3 * ONE, 7, '0, 3 * ONE, 1'b0, 1'b1, 1'b1);
    add_item(-1, -1, -1, -1, 1'b1, 1'b1, 1'b0);
    add_item('0, ONE, '0, 1, 1'b1, 1'b1, 1'b1);
    add_item('0, -1, MIN_CODE, '0, 1'b1, 1'b0, 1'b1);
    drain();

    add_random_vectors(PHASE_ITEMS);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 37;
    add_random_vectors(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_vectors(PHASE_ITEMS);
    @(posedge clk_i);
    hold_arm <= 1'b1;
    @(posedge clk_i);
    hold_arm <= 1'b0;
    drain();

    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending_bounds.size() == 0) begin
      $display("step_bound_info_reduce verification clean");
    end else begin
      $display("step_bound_info_reduce verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("step_bound_info_reduce verification failed");
    $finish;
  end

endmodule

`default_nettype wire
